### sv/mck_pkg.sv
`timescale 1ns / 1ps

package mck_pkg;

    localparam int CHAR_W   = 8;
    localparam int DIT_W    = 16;
    localparam int UNIT_W   = 18;
    localparam int DUR_W    = 20;
    localparam int CFG_W    = 18;
    localparam int PAT_W    = 6;
    localparam int LEN_W    = 3;
    localparam int STEP_W   = 4;

    // register indexes on the configuration port
    localparam logic REG_DIT  = 1'b0;
    localparam logic REG_UNIT = 1'b1;

    localparam logic [DIT_W-1:0]  DIT_RESET  = 16'd1890;
    localparam logic [UNIT_W-1:0] UNIT_RESET = 18'd3015;

    // bits[PAT_W-1] is the first element of the character; 1 = dah, 0 = dit
    typedef struct packed {
        logic             ws;
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] bits;
    } t_entry;

    function automatic t_entry mck_lookup(input logic [CHAR_W-1:0] raw);
        logic [CHAR_W-1:0] c;
        t_entry            e;
        c      = raw;
        e.ws   = 1'b0;
        e.len  = 3'd0;
        e.bits = 6'b000000;
        if ((c >= 8'd9 && c <= 8'd13) || c == 8'd32) begin
            e.ws = 1'b1;
        end else begin
            // fold upper case
            if (c >= 8'h41 && c <= 8'h5a) begin
                c = c + 8'd32;
            end
            unique case (c)
                8'h61: begin e.len = 3'd2; e.bits = 6'b010000; end // a
                8'h62: begin e.len = 3'd4; e.bits = 6'b100000; end // b
                8'h63: begin e.len = 3'd4; e.bits = 6'b101000; end // c
                8'h64: begin e.len = 3'd3; e.bits = 6'b100000; end // d
                8'h65: begin e.len = 3'd1; e.bits = 6'b000000; end // e
                8'h66: begin e.len = 3'd4; e.bits = 6'b001000; end // f
                8'h67: begin e.len = 3'd3; e.bits = 6'b110000; end // g
                8'h68: begin e.len = 3'd4; e.bits = 6'b000000; end // h
                8'h69: begin e.len = 3'd2; e.bits = 6'b000000; end // i
                8'h6a: begin e.len = 3'd4; e.bits = 6'b011100; end // j
                8'h6b: begin e.len = 3'd3; e.bits = 6'b101000; end // k
                8'h6c: begin e.len = 3'd4; e.bits = 6'b010000; end // l
                8'h6d: begin e.len = 3'd2; e.bits = 6'b110000; end // m
                8'h6e: begin e.len = 3'd2; e.bits = 6'b100000; end // n
                8'h6f: begin e.len = 3'd3; e.bits = 6'b111000; end // o
                8'h70: begin e.len = 3'd4; e.bits = 6'b011000; end // p
                8'h71: begin e.len = 3'd4; e.bits = 6'b110100; end // q
                8'h72: begin e.len = 3'd3; e.bits = 6'b010000; end // r
                8'h73: begin e.len = 3'd3; e.bits = 6'b000000; end // s
                8'h74: begin e.len = 3'd1; e.bits = 6'b100000; end // t
                8'h75: begin e.len = 3'd3; e.bits = 6'b001000; end // u
                8'h76: begin e.len = 3'd4; e.bits = 6'b000100; end // v
                8'h77: begin e.len = 3'd3; e.bits = 6'b011000; end // w
                8'h78: begin e.len = 3'd4; e.bits = 6'b100100; end // x
                8'h79: begin e.len = 3'd4; e.bits = 6'b101100; end // y
                8'h7a: begin e.len = 3'd4; e.bits = 6'b110000; end // z
                8'h30: begin e.len = 3'd5; e.bits = 6'b111110; end // 0
                8'h31: begin e.len = 3'd5; e.bits = 6'b011110; end // 1
                8'h32: begin e.len = 3'd5; e.bits = 6'b001110; end // 2
                8'h33: begin e.len = 3'd5; e.bits = 6'b000110; end // 3
                8'h34: begin e.len = 3'd5; e.bits = 6'b000010; end // 4
                8'h35: begin e.len = 3'd5; e.bits = 6'b000000; end // 5
                8'h36: begin e.len = 3'd5; e.bits = 6'b100000; end // 6
                8'h37: begin e.len = 3'd5; e.bits = 6'b110000; end // 7
                8'h38: begin e.len = 3'd5; e.bits = 6'b111000; end // 8
                8'h39: begin e.len = 3'd5; e.bits = 6'b111100; end // 9
                8'h2b: begin e.len = 3'd5; e.bits = 6'b010100; end // plus
                8'h3d: begin e.len = 3'd5; e.bits = 6'b100010; end // equals
                8'h2d: begin e.len = 3'd6; e.bits = 6'b100001; end // hyphen
                8'h27: begin e.len = 3'd6; e.bits = 6'b011110; end // apostrophe
                8'h22: begin e.len = 3'd6; e.bits = 6'b010010; end // quote
                8'h26: begin e.len = 3'd5; e.bits = 6'b010000; end // ampersand
                8'h40: begin e.len = 3'd6; e.bits = 6'b011010; end // at
                8'h2e: begin e.len = 3'd6; e.bits = 6'b010101; end // full stop
                8'h2c: begin e.len = 3'd6; e.bits = 6'b110011; end // comma
                8'h3f: begin e.len = 3'd6; e.bits = 6'b001100; end // question
                8'h2f: begin e.len = 3'd5; e.bits = 6'b100100; end // slash
                8'h3a: begin e.len = 3'd6; e.bits = 6'b111000; end // colon
                8'h28: begin e.len = 3'd5; e.bits = 6'b101100; end // open paren
                8'h29: begin e.len = 3'd6; e.bits = 6'b101101; end // close paren
                8'h21: begin e.len = 3'd6; e.bits = 6'b101011; end // exclamation
                8'h81: begin e.len = 3'd4; e.bits = 6'b001100; end
                8'h92: begin e.len = 3'd4; e.bits = 6'b111000; end
                8'h84: begin e.len = 3'd4; e.bits = 6'b010100; end
                8'h82: begin e.len = 3'd5; e.bits = 6'b001000; end
                8'h8a: begin e.len = 3'd5; e.bits = 6'b010010; end
                8'h85: begin e.len = 3'd5; e.bits = 6'b011010; end
                8'h87: begin e.len = 3'd5; e.bits = 6'b101000; end
                default: begin e.len = 3'd0; e.bits = 6'b000000; end
            endcase
        end
        return e;
    endfunction

endpackage

### sv/mck_front.sv
`timescale 1ns / 1ps

module mck_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [mck_pkg::CHAR_W-1:0] i_char_code,
    input  logic                       i_q_full,
    output logic                       o_push,
    output mck_pkg::t_entry            o_entry
);
    import mck_pkg::*;

    logic   r_valid;
    t_entry r_entry;
    logic   accept;

    assign busy    = r_valid && i_q_full;
    assign accept  = start && !busy;
    assign o_push  = r_valid && !i_q_full;
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // classify and look up the byte on acceptance
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= mck_lookup(i_char_code);
        end
    end

endmodule

### sv/mck_queue.sv
`timescale 1ns / 1ps

module mck_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mck_pkg::t_entry i_data,
    input  logic            i_pop,
    output mck_pkg::t_entry o_data,
    output logic            o_full,
    output logic            o_empty
);
    import mck_pkg::*;

    t_entry     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

### sv/mck_back.sv
`timescale 1ns / 1ps

module mck_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [mck_pkg::DIT_W-1:0]  i_dit,
    input  logic [mck_pkg::UNIT_W-1:0] i_unit,
    input  mck_pkg::t_entry            i_q_data,
    input  logic                       i_q_empty,
    output logic                       o_pop,
    output logic                       o_strobe,
    output logic                       o_tone_on,
    output logic [mck_pkg::DUR_W-1:0]  o_duration,
    output logic                       o_last
);
    import mck_pkg::*;

    logic              r_active;
    t_entry            r_cur;
    logic [STEP_W-1:0] r_step;
    logic              r_strobe;
    logic              r_tone;
    logic [DUR_W-1:0]  r_dur;
    logic              r_last;

    logic              final_el;
    logic [PAT_W-1:0]  pat_shift;
    logic [DUR_W-1:0]  dit_1;
    logic [DUR_W-1:0]  dit_3;
    logic [DUR_W-1:0]  char_gap;
    logic [DUR_W-1:0]  word_gap;
    logic              n_tone;
    logic [DUR_W-1:0]  n_dur;
    logic              n_last;

    assign dit_1    = {4'b0000, i_dit};
    assign dit_3    = {4'b0000, i_dit} + {3'b000, i_dit, 1'b0};
    assign char_gap = {1'b0, i_unit, 1'b0};
    assign word_gap = {i_unit, 2'b00};

    // the character or word gap follows 2*len tone and gap steps
    assign final_el  = r_active && (r_step == {r_cur.len, 1'b0});
    assign o_pop     = (!r_active || final_el) && !i_q_empty;
    assign pat_shift = r_cur.bits << r_step[STEP_W-1:1];

    always_comb begin
        n_tone = 1'b0;
        n_dur  = dit_1;
        n_last = 1'b0;
        if (r_step == {r_cur.len, 1'b0}) begin
            n_dur  = r_cur.ws ? word_gap : char_gap;
            n_last = 1'b1;
        end else if (!r_step[0]) begin
            n_tone = 1'b1;
            n_dur  = pat_shift[PAT_W-1] ? dit_3 : dit_1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_active;
            if (o_pop) begin
                r_active <= 1'b1;
            end else if (final_el) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur  <= i_q_data;
            r_step <= '0;
        end else begin
            r_step <= r_step + STEP_W'(1);
        end
        r_tone <= n_tone;
        r_dur  <= n_dur;
        r_last <= n_last;
    end

    assign o_strobe   = r_strobe;
    assign o_tone_on  = r_tone;
    assign o_duration = r_dur;
    assign o_last     = r_last;

`ifndef SYNTHESIS
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_step <= {r_cur.len, 1'b0}))
        else $error("element step past character end");
    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_active && r_step == '0))
        else $error("popped item did not start at first element");
    a_ws_no_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && r_cur.ws) |-> (r_cur.len == '0))
        else $error("whitespace item carries a pattern");
`endif

endmodule

### sv/morse_character_keyer.sv
`timescale 1ns / 1ps
// An item passes the front-end register, the queue, the sequencer state and the output
// registers. An n-element pattern (0 to 6) is keyed as tone and gap steps, then a
// character or word gap; a two-entry queue takes new items while one is keyed, so items
// follow with no gap. Results carry o_strobe for one cycle; the receiver cannot stall.
// Reset (synchronous, active low) empties the queue and sequencer and loads the
// register defaults: dit 1890 samples, space unit 3015 samples.

module morse_character_keyer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [mck_pkg::CHAR_W-1:0] i_char_code,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [mck_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                       o_strobe,
    output logic                       o_tone_on,
    output logic [mck_pkg::DUR_W-1:0]  o_duration,
    output logic                       o_last
);
    import mck_pkg::*;

    logic [DIT_W-1:0]  r_dit;
    logic [UNIT_W-1:0] r_unit;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    t_entry            front_entry;
    t_entry            q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dit  <= DIT_RESET;
            r_unit <= UNIT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_DIT) begin
                r_dit <= i_cfg_data[DIT_W-1:0];
            end else begin
                r_unit <= i_cfg_data[UNIT_W-1:0];
            end
        end
    end

    mck_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_char_code (i_char_code),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_entry     (front_entry)
    );

    mck_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_entry),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mck_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dit      (r_dit),
        .i_unit     (r_unit),
        .i_q_data   (q_data),
        .i_q_empty  (q_empty),
        .o_pop      (pop),
        .o_strobe   (o_strobe),
        .o_tone_on  (o_tone_on),
        .o_duration (o_duration),
        .o_last     (o_last)
    );

endmodule
